FILE: hdl/ronl_pkg.sv
// ronl_pkg: field widths, register indexes and operation codes shared by the
// ring owner and neighbor lookup core
// no dependencies

package ronl_pkg;

  // fixed field widths
  localparam int PEER_ID_W     = 5;
  localparam int ISLAND_ID_W   = 10;
  localparam int SUCC_CNT_W    = 5;
  localparam int PEER_CNT_W    = 6;
  localparam int ISLAND_CNT_W  = 11;
  localparam int ACTIVE_CNT_W  = 6;

  // common width for member number compares (holds up to 255)
  localparam int PEER_EXT_W    = 8;

  // configuration port
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = ISLAND_CNT_W;

  localparam logic [CFG_IDX_W-1:0] CFG_PEER_COUNT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ISLAND_COUNT = 1'b1;

  // reset values of the registers
  localparam logic [PEER_CNT_W-1:0]   PEER_COUNT_RST   = 6'd32;
  localparam logic [ISLAND_CNT_W-1:0] ISLAND_COUNT_RST = 11'd1024;

  // saturation value of the active count port
  localparam logic [ACTIVE_CNT_W-1:0] ACTIVE_CNT_MAX = 6'd63;

  // operation codes
  localparam logic OP_QUERY  = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // width of the bit index into the island number fed to the remainder unit, msb first
  localparam int DIV_BIT_W = $clog2(ISLAND_ID_W);

  function automatic logic [PEER_ID_W-1:0] to_peer_id(input logic [PEER_EXT_W-1:0] v);
    return v[PEER_ID_W-1:0];
  endfunction

endpackage

FILE: hdl/ring_owner_and_neighbor_lookup_core.sv
// ring_owner_and_neighbor_lookup_core: active member mask, island owner by
// remainder over the active count, predecessor and successor walks
// depends on ronl_pkg

// channel   | ports                                         | handshake
// ----------+-----------------------------------------------+---------------------------------
// item in   | operation_i peer_id_i island_id_i             | start_i, taken when busy_o low
//           | successor_count_i                             |
// result    | owner_o owner_valid_o predecessor_o           | result_valid_o one-cycle strobe
//           | successor_o successor_valid_o peer_active_o   |
//           | active_count_o last_o                         |
// config    | cfg_idx_i cfg_wdata_i                         | cfg_we_i, written at once
//
// a remove is done in ST_IDLE and busy_o never rises for it
// a query counts the active members in use (ST_COUNT), runs a one-bit-a-step
// remainder unit (ST_DIV) when the owner is valid, scans for the owner
// (ST_OWNER), walks back for the predecessor (ST_PRED), walks forward once per
// listed successor (ST_SUCC), with one more walk when the run wraps back to the
// member, and passes a setup and a close state (ST_SETUP, ST_DONE); one ring
// pointer with its step unit does both walks, a scan counter the two scans
// reset sets every member active, peer_count to 32 and island_count to 1024
// results are strobes the receiver cannot hold off; a run ends with last_o

module ring_owner_and_neighbor_lookup_core
  import ronl_pkg::*;
#(
  parameter int MAX_PEERS   = 32,
  parameter int MAX_ISLANDS = 1024
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,

  input  logic                    start_i,
  output logic                    busy_o,
  input  logic                    operation_i,
  input  logic [PEER_ID_W-1:0]    peer_id_i,
  input  logic [ISLAND_ID_W-1:0]  island_id_i,
  input  logic [SUCC_CNT_W-1:0]   successor_count_i,

  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata_i,

  output logic                    result_valid_o,
  output logic [PEER_ID_W-1:0]    owner_o,
  output logic                    owner_valid_o,
  output logic [PEER_ID_W-1:0]    predecessor_o,
  output logic [PEER_ID_W-1:0]    successor_o,
  output logic                    successor_valid_o,
  output logic                    peer_active_o,
  output logic [ACTIVE_CNT_W-1:0] active_count_o,
  output logic                    last_o
);

  // index width and count width of the member set
  localparam int IW = $clog2(MAX_PEERS);
  localparam int PW = $clog2(MAX_PEERS + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_COUNT, ST_DIV, ST_OWNER, ST_SETUP, ST_PRED, ST_SUCC, ST_DONE
  } state_e;

  // member is in use and active
  function automatic logic is_on(input logic [MAX_PEERS-1:0] mask,
                                 input logic [PW-1:0] n, input logic [IW-1:0] idx);
    return (PW'(idx) < n) && mask[idx];
  endfunction

  // one step around the ring of n members
  function automatic logic [IW-1:0] ring_inc(input logic [PW-1:0] n,
                                             input logic [IW-1:0] p);
    logic [PW-1:0] nxt;
    nxt = PW'(p) + PW'(1);
    return (nxt == n) ? '0 : nxt[IW-1:0];
  endfunction

  function automatic logic [IW-1:0] ring_dec(input logic [PW-1:0] n,
                                             input logic [IW-1:0] p);
    logic [PW-1:0] top;
    top = n - PW'(1);
    return (p == '0) ? top[IW-1:0] : p - IW'(1);
  endfunction

  // registers
  state_e                  state_q, state_d;
  logic [MAX_PEERS-1:0]    mask_q, mask_d;
  logic [PEER_CNT_W-1:0]   peer_count_q;
  logic [ISLAND_CNT_W-1:0] island_count_q;
  logic [PEER_ID_W-1:0]    pid_q, pid_d;
  logic [ISLAND_ID_W-1:0]  isl_q, isl_d;
  logic [SUCC_CNT_W-1:0]   k_left_q, k_left_d;
  logic [PW-1:0]           scan_q, scan_d;
  logic [PW-1:0]           cnt_q, cnt_d;
  logic [PW-1:0]           seen_q, seen_d;
  logic [PW-1:0]           rem_q, rem_d;
  logic [DIV_BIT_W-1:0]    bit_q, bit_d;
  logic [IW-1:0]           ptr_q, ptr_d;
  logic [PW-1:0]           off_q, off_d;
  logic [PEER_ID_W-1:0]    owner_q, owner_d;
  logic                    owner_valid_q, owner_valid_d;
  logic [PEER_ID_W-1:0]    pred_q, pred_d;
  logic                    pact_q, pact_d;
  logic [IW-1:0]           pend_q, pend_d;
  logic                    pend_valid_q, pend_valid_d;
  logic                    res_valid_q, res_valid_d;

  // output payload registers
  logic [PEER_ID_W-1:0]    res_owner_q;
  logic                    res_owner_valid_q;
  logic [PEER_ID_W-1:0]    res_pred_q;
  logic [PEER_ID_W-1:0]    res_succ_q;
  logic                    res_succ_valid_q;
  logic                    res_pact_q;
  logic [ACTIVE_CNT_W-1:0] res_acnt_q;
  logic                    res_last_q;

  // emit request from the sequencer
  logic                    emit;
  logic                    emit_sv;
  logic [IW-1:0]           emit_succ;
  logic                    emit_last;

  // members in use, saturated
  logic [PEER_EXT_W-1:0]   pc_ext;
  logic [PEER_EXT_W-1:0]   n_ext;
  logic [PW-1:0]           n_c;

  assign pc_ext = PEER_EXT_W'(peer_count_q);
  assign n_ext  = (pc_ext > PEER_EXT_W'(MAX_PEERS)) ? PEER_EXT_W'(MAX_PEERS) : pc_ext;
  assign n_c    = n_ext[PW-1:0];

  // incoming member number against the ring
  logic [PEER_EXT_W-1:0]   pid_in_ext;
  logic [IW-1:0]           pid_in_idx;
  logic                    pid_in_range;

  assign pid_in_ext   = PEER_EXT_W'(peer_id_i);
  assign pid_in_idx   = pid_in_ext[IW-1:0];
  assign pid_in_range = pid_in_ext < n_ext;

  // stored member number against the ring
  logic [PEER_EXT_W-1:0]   pid_ext;
  logic [IW-1:0]           pid_idx;
  logic                    pid_range;

  assign pid_ext   = PEER_EXT_W'(pid_q);
  assign pid_idx   = pid_ext[IW-1:0];
  assign pid_range = pid_ext < n_ext;

  // island below the saturated island count
  logic                    isl_ok;

  assign isl_ok = (32'(island_count_q) > MAX_ISLANDS) ? (32'(isl_q) < MAX_ISLANDS)
                                                        : (ISLAND_CNT_W'(isl_q) < island_count_q);

  // remainder unit: one dividend bit a cycle
  logic [PW:0]             div_trial;
  logic [PW:0]             div_sub;

  assign div_trial = {rem_q, isl_q[bit_q]};
  assign div_sub   = div_trial - (PW + 1)'(cnt_q);

  // shared ring walk step
  logic [IW-1:0]           step_c;
  logic                    step_on;
  logic                    walk_end;
  logic [IW-1:0]           scan_idx;
  logic                    scan_on;

  assign step_c   = (state_q == ST_PRED) ? ring_dec(n_c, ptr_q) : ring_inc(n_c, ptr_q);
  assign step_on  = is_on(mask_q, n_c, step_c);
  assign walk_end = (off_q == n_c);
  assign scan_idx = scan_q[IW-1:0];
  assign scan_on  = (scan_q < n_c) && is_on(mask_q, n_c, scan_idx);

  // walk result: the step member; when the lap closes the step lands back on
  // the start member
  logic [IW-1:0]           found;

  assign found = step_c;

  // active count for the result
  logic [PEER_EXT_W-1:0]   cnt_ext;
  logic [ACTIVE_CNT_W-1:0] acnt;

  assign cnt_ext = PEER_EXT_W'(cnt_q);
  assign acnt    = (cnt_ext > PEER_EXT_W'(ACTIVE_CNT_MAX)) ? ACTIVE_CNT_MAX
                                                            : cnt_ext[ACTIVE_CNT_W-1:0];

  // sequencer next state
  always_comb begin
    state_d       = state_q;
    mask_d        = mask_q;
    pid_d         = pid_q;
    isl_d         = isl_q;
    k_left_d      = k_left_q;
    scan_d        = scan_q;
    cnt_d         = cnt_q;
    seen_d        = seen_q;
    rem_d         = rem_q;
    bit_d         = bit_q;
    ptr_d         = ptr_q;
    off_d         = off_q;
    owner_d       = owner_q;
    owner_valid_d = owner_valid_q;
    pred_d        = pred_q;
    pact_d        = pact_q;
    pend_d        = pend_q;
    pend_valid_d  = pend_valid_q;
    res_valid_d   = 1'b0;
    emit          = 1'b0;
    emit_sv       = 1'b0;
    emit_succ     = pend_q;
    emit_last     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          pid_d    = peer_id_i;
          isl_d    = island_id_i;
          k_left_d = successor_count_i;
          if (operation_i == OP_REMOVE) begin
            if (pid_in_range && mask_q[pid_in_idx]) begin
              mask_d[pid_in_idx] = 1'b0;
            end
          end else begin
            scan_d       = '0;
            cnt_d        = '0;
            pend_valid_d = 1'b0;
            state_d      = ST_COUNT;
          end
        end
      end

      // count active members, one per cycle
      ST_COUNT: begin
        if (scan_q == n_c) begin
          if ((cnt_q != '0) && isl_ok) begin
            rem_d   = '0;
            bit_d   = DIV_BIT_W'(ISLAND_ID_W - 1);
            state_d = ST_DIV;
          end else begin
            owner_d       = '0;
            owner_valid_d = 1'b0;
            state_d       = ST_SETUP;
          end
        end else begin
          cnt_d  = cnt_q + PW'(scan_on);
          scan_d = scan_q + PW'(1);
        end
      end

      // island mod active count, restoring, msb first
      ST_DIV: begin
        rem_d = (div_trial >= (PW + 1)'(cnt_q)) ? div_sub[PW-1:0] : div_trial[PW-1:0];
        if (bit_q == '0) begin
          scan_d  = '0;
          seen_d  = '0;
          state_d = ST_OWNER;
        end else begin
          bit_d = bit_q - DIV_BIT_W'(1);
        end
      end

      // find the active member whose rank equals the remainder
      ST_OWNER: begin
        if (scan_q == n_c) begin
          state_d = ST_SETUP;
        end else begin
          scan_d = scan_q + PW'(1);
          if (scan_on) begin
            if (seen_q == rem_q) begin
              owner_d       = to_peer_id(PEER_EXT_W'(scan_q));
              owner_valid_d = 1'b1;
              state_d       = ST_SETUP;
            end else begin
              seen_d = seen_q + PW'(1);
            end
          end
        end
      end

      // queried member flags and walk start
      ST_SETUP: begin
        pact_d = pid_range && mask_q[pid_idx];
        if (pid_range) begin
          ptr_d   = pid_idx;
          off_d   = PW'(1);
          state_d = ST_PRED;
        end else begin
          pred_d  = pid_q;
          state_d = ST_DONE;
        end
      end

      // backward walk to the nearest active member
      ST_PRED: begin
        if (walk_end || step_on) begin
          pred_d = walk_end ? pid_q : to_peer_id(PEER_EXT_W'(step_c));
          if (k_left_q == '0) begin
            state_d = ST_DONE;
          end else begin
            ptr_d   = pid_idx;
            off_d   = PW'(1);
            state_d = ST_SUCC;
          end
        end else begin
          ptr_d = step_c;
          off_d = off_q + PW'(1);
        end
      end

      // forward walks, one successor each; a found one is held pending until the
      // next is found or the run closes, so the final result can carry last
      ST_SUCC: begin
        if (walk_end || step_on) begin
          if (found == pid_idx) begin
            state_d = ST_DONE;
          end else begin
            if (pend_valid_q) begin
              emit    = 1'b1;
              emit_sv = 1'b1;
            end
            pend_d       = found;
            pend_valid_d = 1'b1;
            k_left_d     = k_left_q - SUCC_CNT_W'(1);
            if (k_left_q == SUCC_CNT_W'(1)) begin
              state_d = ST_DONE;
            end else begin
              ptr_d = found;
              off_d = PW'(1);
            end
          end
        end else begin
          ptr_d = step_c;
          off_d = off_q + PW'(1);
        end
      end

      // closing result of the run
      ST_DONE: begin
        emit      = 1'b1;
        emit_sv   = pend_valid_q;
        emit_last = 1'b1;
        state_d   = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (emit) begin
      res_valid_d = 1'b1;
    end
  end

  // sequencer state, member mask and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      mask_q        <= '1;
      k_left_q      <= '0;
      scan_q        <= '0;
      cnt_q         <= '0;
      seen_q        <= '0;
      rem_q         <= '0;
      bit_q         <= '0;
      ptr_q         <= '0;
      off_q         <= '0;
      owner_valid_q <= 1'b0;
      pact_q        <= 1'b0;
      pend_valid_q  <= 1'b0;
      res_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      mask_q        <= mask_d;
      k_left_q      <= k_left_d;
      scan_q        <= scan_d;
      cnt_q         <= cnt_d;
      seen_q        <= seen_d;
      rem_q         <= rem_d;
      bit_q         <= bit_d;
      ptr_q         <= ptr_d;
      off_q         <= off_d;
      owner_valid_q <= owner_valid_d;
      pact_q        <= pact_d;
      pend_valid_q  <= pend_valid_d;
      res_valid_q   <= res_valid_d;
    end
  end

  // item fields and result payload
  always_ff @(posedge clk_i) begin
    pid_q   <= pid_d;
    isl_q   <= isl_d;
    owner_q <= owner_d;
    pred_q  <= pred_d;
    pend_q  <= pend_d;
    if (emit) begin
      res_owner_q       <= owner_q;
      res_owner_valid_q <= owner_valid_q;
      res_pred_q        <= pred_q;
      res_succ_q        <= emit_sv ? to_peer_id(PEER_EXT_W'(emit_succ)) : '0;
      res_succ_valid_q  <= emit_sv;
      res_pact_q        <= pact_q;
      res_acnt_q        <= acnt;
      res_last_q        <= emit_last;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peer_count_q   <= PEER_COUNT_RST;
      island_count_q <= ISLAND_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PEER_COUNT:   peer_count_q   <= cfg_wdata_i[PEER_CNT_W-1:0];
        CFG_ISLAND_COUNT: island_count_q <= cfg_wdata_i;
        default:          island_count_q <= island_count_q;
      endcase
    end
  end

  // outputs
  assign busy_o            = (state_q != ST_IDLE);
  assign result_valid_o    = res_valid_q;
  assign owner_o           = res_owner_q;
  assign owner_valid_o     = res_owner_valid_q;
  assign predecessor_o     = res_pred_q;
  assign successor_o       = res_succ_q;
  assign successor_valid_o = res_succ_valid_q;
  assign peer_active_o     = res_pact_q;
  assign active_count_o    = res_acnt_q;
  assign last_o            = res_last_q;

  // a beat that is not the last leaves the run still going
  a_mid_beat_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> busy_o)
    else $error("non-final beat while idle");

  // an owner exists only with some member active
  a_owner_needs_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && owner_valid_o |-> active_count_o != '0)
    else $error("owner reported with no active member");

  // members are only ever removed
  a_mask_falls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (mask_q & ~$past(mask_q)) == '0)
    else $error("member came back to active");

  // a ring walk never goes past one lap and starts from a member in range
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PRED || state_q == ST_SUCC) |-> (off_q <= n_c) && pid_range)
    else $error("ring walk out of bounds");

endmodule
